// ===== src/amgs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Adjacency matrix graph store: shared types and constants
// Request layout, result layout, operation codes and sequencer states used by
// the controller and the top level.
// ----------------------------------------------------------------------------
package amgs_pkg;

    localparam int MAX_VERTICES_DEF = 16;

    typedef enum logic [2:0] {
        MODE_ADD_VERTEX   = 3'd0,
        MODE_SET_EDGE     = 3'd1,
        MODE_DEL_VERTEX   = 3'd2,
        MODE_CLR_EDGE     = 3'd3,
        MODE_EDGE_QUERY   = 3'd4,
        MODE_VERTEX_QUERY = 3'd5
    } t_mode;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE2,
        ST_EQ_WAIT,
        ST_VQ_RD,
        ST_VQ_CMP,
        ST_DM_RD,
        ST_DM_WR,
        ST_DL_RD,
        ST_DL_WR,
        ST_DONE
    } t_state;

    // Packed so that mode sits in the lowest bits.
    typedef struct packed {
        logic [15:0] edge_weight;
        logic [3:0]  second_vertex;
        logic [15:0] first_vertex;
        logic [2:0]  mode;
    } t_item;

    // Packed so that hit sits in the lowest bit.
    typedef struct packed {
        logic       error;
        logic [4:0] vertex_total;
        logic       hit;
    } t_result;

endpackage : amgs_pkg
`default_nettype wire

// ===== src/amgs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module amgs_ram #(
    parameter int AW = 8,
    parameter int DW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [(1 << AW)];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule : amgs_ram
`default_nettype wire

// ===== src/amgs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Adjacency matrix graph store: sequencer
// Decodes each request, drives the weight and label RAMs through the clearing
// pass, edge writes, queries and the compacting delete walk, and holds the
// result register.
// ----------------------------------------------------------------------------
module amgs_ctrl #(
    parameter  int MAX_VERTICES = amgs_pkg::MAX_VERTICES_DEF,
    localparam int IW           = $clog2(MAX_VERTICES)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire amgs_pkg::t_item   i_item,
    input  wire logic              i_item_valid,
    output logic                   o_item_ready,
    output amgs_pkg::t_result      o_res,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output logic                   o_w_we,
    output logic      [2*IW-1:0]   o_w_waddr,
    output logic      [15:0]       o_w_wdata,
    output logic      [2*IW-1:0]   o_w_raddr,
    input  wire logic [15:0]       i_w_rdata,
    output logic                   o_l_we,
    output logic      [IW-1:0]     o_l_waddr,
    output logic      [15:0]       o_l_wdata,
    output logic      [IW-1:0]     o_l_raddr,
    input  wire logic [15:0]       i_l_rdata
);
    import amgs_pkg::*;

    localparam int             CW       = $clog2(MAX_VERTICES + 1);
    localparam logic [IW-1:0]  LAST_IDX = IW'(MAX_VERTICES - 1);
    localparam logic [CW-1:0]  FULL_CNT = CW'(MAX_VERTICES);
    localparam logic [15:0]    LIMIT16  = 16'(MAX_VERTICES);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_last,  n_last;
    logic [IW-1:0] r_row,   n_row;
    logic [IW-1:0] r_col,   n_col;
    logic [IW-1:0] r_pos,   n_pos;
    logic [15:0]   r_wgt,   n_wgt;
    logic          r_hit,   n_hit;
    logic          r_err,   n_err;
    t_result       r_res,   n_res;
    logic          r_res_valid, n_res_valid;

    logic [IW-1:0] a_idx;
    logic [IW+3:0] b_ext;
    logic [IW-1:0] b_idx;
    logic          in_range;
    logic          pos_ok;
    logic          at_edge;
    logic          row_end;
    logic          col_end;
    logic [IW-1:0] src_row;
    logic [IW-1:0] src_col;
    logic [CW+4:0] total_ext;

    assign a_idx    = i_item.first_vertex[IW-1:0];
    assign b_ext    = {{IW{1'b0}}, i_item.second_vertex};
    assign b_idx    = b_ext[IW-1:0];
    assign in_range = (i_item.first_vertex < LIMIT16) &&
                      ({12'd0, i_item.second_vertex} < LIMIT16);
    assign pos_ok   = i_item.first_vertex < 16'(r_count);

    // During a delete every entry of the held square takes the entry that
    // lies one row or column further on past the deleted position; the last
    // row and column of the square fall free and are written with zero.
    assign row_end  = CW'(r_row) == r_last;
    assign col_end  = CW'(r_col) == r_last;
    assign at_edge  = row_end || col_end;
    assign src_row  = r_row + IW'(r_row >= r_pos);
    assign src_col  = r_col + IW'(r_col >= r_pos);

    assign total_ext = {5'd0, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_count     <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_row       <= n_row;
            r_col       <= n_col;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_pos  <= n_pos;
        r_wgt  <= n_wgt;
        r_hit  <= n_hit;
        r_err  <= n_err;
        r_res  <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_last      = r_last;
        n_row       = r_row;
        n_col       = r_col;
        n_pos       = r_pos;
        n_wgt       = r_wgt;
        n_hit       = r_hit;
        n_err       = r_err;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_res_ready;

        o_item_ready = 1'b0;
        o_w_we       = 1'b0;
        o_w_waddr    = {r_row, r_col};
        o_w_wdata    = '0;
        o_w_raddr    = {src_row, src_col};
        o_l_we       = 1'b0;
        o_l_waddr    = r_row;
        o_l_wdata    = i_l_rdata;
        o_l_raddr    = r_row;

        case (r_state)
            ST_CLEAR: begin
                o_w_we = 1'b1;
                if (r_col == LAST_IDX) begin
                    n_col = '0;
                    if (r_row == LAST_IDX) begin
                        n_row   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_row = r_row + IW'(1);
                    end
                end else begin
                    n_col = r_col + IW'(1);
                end
            end

            ST_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    n_hit   = 1'b0;
                    n_err   = 1'b0;
                    n_state = ST_DONE;
                    n_wgt   = i_item.first_vertex;
                    n_last  = r_count - CW'(1);
                    case (t_mode'(i_item.mode))
                        MODE_ADD_VERTEX: begin
                            if (r_count == FULL_CNT) begin
                                n_err = 1'b1;
                            end else begin
                                o_l_we    = 1'b1;
                                o_l_waddr = r_count[IW-1:0];
                                o_l_wdata = i_item.first_vertex;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        MODE_SET_EDGE, MODE_CLR_EDGE: begin
                            if (!in_range) begin
                                n_err = 1'b1;
                            end else begin
                                o_w_we    = 1'b1;
                                o_w_waddr = {a_idx, b_idx};
                                o_w_wdata = (t_mode'(i_item.mode) == MODE_SET_EDGE) ?
                                            i_item.edge_weight : 16'd0;
                                n_wgt     = o_w_wdata;
                                n_row     = b_idx;
                                n_col     = a_idx;
                                n_state   = ST_EDGE2;
                            end
                        end
                        MODE_EDGE_QUERY: begin
                            if (!in_range) begin
                                n_err = 1'b1;
                            end else begin
                                o_w_raddr = {a_idx, b_idx};
                                n_state   = ST_EQ_WAIT;
                            end
                        end
                        MODE_DEL_VERTEX: begin
                            if (!pos_ok) begin
                                n_err = 1'b1;
                            end else begin
                                n_pos   = a_idx;
                                n_row   = '0;
                                n_col   = '0;
                                n_state = ST_DM_RD;
                            end
                        end
                        MODE_VERTEX_QUERY: begin
                            if (r_count != '0) begin
                                n_row   = '0;
                                n_state = ST_VQ_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_EDGE2: begin
                // Mirror write of the symmetric entry.
                o_w_we    = 1'b1;
                o_w_wdata = r_wgt;
                n_state   = ST_DONE;
            end

            ST_EQ_WAIT: begin
                n_hit   = (i_w_rdata != 16'd0) && !i_w_rdata[15];
                n_state = ST_DONE;
            end

            ST_VQ_RD: begin
                n_state = ST_VQ_CMP;
            end

            ST_VQ_CMP: begin
                n_hit = r_hit || (i_l_rdata == r_wgt);
                if (row_end) begin
                    n_state = ST_DONE;
                end else begin
                    n_row   = r_row + IW'(1);
                    n_state = ST_VQ_RD;
                end
            end

            ST_DM_RD: begin
                n_state = ST_DM_WR;
            end

            ST_DM_WR: begin
                o_w_we    = 1'b1;
                o_w_wdata = at_edge ? 16'd0 : i_w_rdata;
                n_state   = ST_DM_RD;
                if (col_end) begin
                    n_col = '0;
                    if (row_end) begin
                        n_row = r_pos;
                        if (CW'(r_pos) == r_last) begin
                            n_count = r_last;
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_DL_RD;
                        end
                    end else begin
                        n_row = r_row + IW'(1);
                    end
                end else begin
                    n_col = r_col + IW'(1);
                end
            end

            ST_DL_RD: begin
                o_l_raddr = r_row + IW'(1);
                n_state   = ST_DL_WR;
            end

            ST_DL_WR: begin
                o_l_we = 1'b1;
                if (CW'(r_row) + CW'(1) == r_last) begin
                    n_count = r_last;
                    n_state = ST_DONE;
                end else begin
                    n_row   = r_row + IW'(1);
                    n_state = ST_DL_RD;
                end
            end

            ST_DONE: begin
                if (!r_res_valid || i_res_ready) begin
                    n_res.hit          = r_hit;
                    n_res.error        = r_err;
                    n_res.vertex_total = total_ext[4:0];
                    n_res_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule : amgs_ctrl
`default_nettype wire

// ===== src/adjacency_matrix_graph_store_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Adjacency matrix graph store
// Symmetric weighted adjacency matrix with a vertex label list and count.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel, one per handshake; each request gives
// exactly one result on the m_axis channel, in order. The weight matrix lives
// in a RAM of 2**(2*IW) entries (MAX_VERTICES squared for a power of two)
// and the labels in a second RAM; both have a single write port, so
// requests are handled one at a time. A delete walks every matrix entry of
// the held square, reading it and writing it back, then moves each label
// above the deleted position down one place.
// A new request can be taken once the previous result is loaded, even
// while that result still waits on m_axis. If the receiver stalls with a
// result waiting, the next result is held until the register is free.
// After reset the weight RAM is cleared one entry a cycle, rows and columns
// 0 to MAX_VERTICES-1, while s_axis_tready stays low. Labels are not cleared.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store_unit #(
    parameter int MAX_VERTICES = amgs_pkg::MAX_VERTICES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // mode[2:0], first_vertex[18:3], second_vertex[22:19], edge_weight[38:23]
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // hit[0], vertex_total[5:1], error[6]
    output logic      [7:0]  m_axis_tdata
);
    import amgs_pkg::*;

    localparam int IW = $clog2(MAX_VERTICES);

    t_item          item;
    t_result        res;
    logic           w_we;
    logic [2*IW-1:0] w_waddr;
    logic [15:0]    w_wdata;
    logic [2*IW-1:0] w_raddr;
    logic [15:0]    w_rdata;
    logic           l_we;
    logic [IW-1:0]  l_waddr;
    logic [15:0]    l_wdata;
    logic [IW-1:0]  l_raddr;
    logic [15:0]    l_rdata;

    assign item         = t_item'(s_axis_tdata[38:0]);
    assign m_axis_tdata = {1'b0, res};

    amgs_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (s_axis_tready),
        .o_res        (res),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_w_we       (w_we),
        .o_w_waddr    (w_waddr),
        .o_w_wdata    (w_wdata),
        .o_w_raddr    (w_raddr),
        .i_w_rdata    (w_rdata),
        .o_l_we       (l_we),
        .o_l_waddr    (l_waddr),
        .o_l_wdata    (l_wdata),
        .o_l_raddr    (l_raddr),
        .i_l_rdata    (l_rdata)
    );

    amgs_ram #(
        .AW (2 * IW),
        .DW (16)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    amgs_ram #(
        .AW (IW),
        .DW (16)
    ) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

`ifndef SYNTH
    // Requests are handled one at a time: taking one closes the input.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another was in progress");

    // A refused request never reports a hit.
    a_no_hit_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[6]))
        else $error("result shows both hit and error");

    // The reported count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((MAX_VERTICES > 31) ||
                           (m_axis_tdata[5:1] <= 5'(MAX_VERTICES))))
        else $error("vertex count beyond capacity");
`endif

endmodule : adjacency_matrix_graph_store_unit
`default_nettype wire
